>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Immediate-consequence and next-cycle property checks, clocked and
// disabled during reset. Compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/idft_pkg.sv
// ---------------------------------------------------------------------------
// idft_pkg
// Shared types and constants of the id filter table match accumulator.
// ---------------------------------------------------------------------------
package idft_pkg;

    // command carried in the input tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned EIU_W = 7;
    localparam logic [EIU_W-1:0] RESET_ENTRIES_IN_USE = 7'd36;

    // field widths
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TYPE_W  = 8;
    localparam int unsigned FLAGS_W = 16;
    localparam int unsigned MASK_W  = 32;
    localparam int unsigned SUM_W   = 32;

    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [TYPE_W-1:0]  etype;
        logic [DATA_W-1:0]  data;
        logic [ID_W-1:0]    id;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic wr_en;    // store the accepted load entry
        logic start;    // begin a query
        logic rd_en;    // read the next table entry
        logic finish;   // push the masked sum to the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pos_lt_count; // entries remain to be read
        logic rd_busy;      // a read is still in flight
        logic out_free;     // output register can take a result
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

>>> hdl/idft_datapath.sv
// ---------------------------------------------------------------------------
// idft_datapath
// Filter table memory, configuration registers, scan counter, match and
// accumulate stage, and the output register.
// ---------------------------------------------------------------------------
module idft_datapath
    import idft_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  t_entry                i_entry,
    input  logic [TYPE_W-1:0]     i_query_type,
    input  logic [MASK_W-1:0]     i_result_mask,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SUM_W-1:0]      o_masked_sum
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = (CW > EIU_W) ? CW : EIU_W;

    t_entry              r_table [MAX_ENTRIES];
    t_entry              r_rd_data;
    logic                r_rd_vld;
    logic [ID_W-1:0]     r_expected_id;
    logic [FLAGS_W-1:0]  r_flag_mask;
    logic [EIU_W-1:0]    r_entries_in_use;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [TYPE_W-1:0]   r_qtype;
    logic [MASK_W-1:0]   r_rmask;
    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_sum;

    logic [SW-1:0]       w_eiu_wide;
    logic [SW-1:0]       w_max_wide;
    logic [CW-1:0]       n_count;
    logic                w_idx_ok;
    logic                w_hit;
    logic [SUM_W-1:0]    w_addend;
    logic [SUM_W-1:0]    n_sum;

    // scan length saturates at the table depth
    assign w_eiu_wide = SW'(r_entries_in_use);
    assign w_max_wide = SW'(MAX_ENTRIES);
    assign n_count    = (w_eiu_wide > w_max_wide) ? w_max_wide[CW-1:0] : w_eiu_wide[CW-1:0];

    assign w_idx_ok = (int'(i_entry_index) < MAX_ENTRIES);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id    <= '0;
            r_flag_mask      <= '0;
            r_entries_in_use <= RESET_ENTRIES_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EXPECTED_ID:    r_expected_id    <= i_cfg_data[ID_W-1:0];
                REG_FLAG_MASK:      r_flag_mask      <= i_cfg_data[FLAGS_W-1:0];
                REG_ENTRIES_IN_USE: r_entries_in_use <= i_cfg_data[EIU_W-1:0];
                default: ;
            endcase
        end
    end

    // table memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_idx_ok) begin
            r_table[AW'(i_entry_index)] <= i_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_table[r_pos[AW-1:0]];
        end
    end

    // match and accumulate on the registered read data
    assign w_hit = r_rd_vld
                && (r_rd_data.id == r_expected_id)
                && (r_rd_data.etype == r_qtype)
                && ((r_rd_data.flags & r_flag_mask) != '0);
    assign w_addend = w_hit ? {{(SUM_W-DATA_W){r_rd_data.data[DATA_W-1]}}, r_rd_data.data}
                            : '0;
    assign n_sum = r_sum + w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_sum    <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_pos   <= '0;
                r_count <= n_count;
                r_sum   <= '0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_pos <= r_pos + 1'b1;
                end
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qtype <= i_query_type;
            r_rmask <= i_result_mask;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_sum <= r_sum & r_rmask;
        end
    end

    assign o_status.pos_lt_count = (r_pos < r_count);
    assign o_status.rd_busy      = r_rd_vld;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_masked_sum = r_out_sum;

endmodule

>>> hdl/idft_ctrl.sv
// ---------------------------------------------------------------------------
// idft_ctrl
// Sequencer: takes load and query transfers, steps the table scan and
// hands the finished sum to the output register.
// ---------------------------------------------------------------------------
module idft_ctrl
    import idft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.pos_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // last entry must be summed and the output slot free
                if (i_status.out_free && !i_status.rd_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/id_filter_table_match_accumulate.sv
// ---------------------------------------------------------------------------
// id_filter_table_match_accumulate
// Message-filter table with a match-and-accumulate query.
// ---------------------------------------------------------------------------
// A table of MAX_ENTRIES filter entries (id, signed data byte, type byte,
// flag word) is written by load transfers and scanned by query transfers.
// A query walks entries 0 to entries_in_use-1 (capped at MAX_ENTRIES),
// adding the sign-extended data byte of every entry whose id equals
// expected_id, whose type equals the query type and whose flags share a
// set bit with flag_mask; the wrapping 32-bit sum, ANDed with the query's
// result mask, is sent as one output transfer. Loads give no output.
// A load is written as it is accepted. A query scans the capped
// entries_in_use entries (36 at the reset value): the single read
// port of the table memory delivers one entry per cycle, the registered read
// data is summed and handed to the output register. A result waiting in the
// output register does not block the next transfer; only the hand-off of a
// second query result waits for it to be taken. The table is not cleared at
// reset: an entry must be loaded before any query scans it. Configuration
// writes are accepted every cycle and must only be made while the block is
// idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module id_filter_table_match_accumulate
    import idft_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] entry_index, [21:6] entry_id, [29:22] entry_data,
    // [37:30] entry_type, [53:38] entry_flags, [61:54] query_type,
    // [93:62] result_mask, [95:94] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd (0 load, 1 query)
    input  logic                   s_axis_tuser,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] masked_sum
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_entry     w_entry;

    // unpack the input transfer
    assign w_entry.id    = s_axis_tdata[21:6];
    assign w_entry.data  = s_axis_tdata[29:22];
    assign w_entry.etype = s_axis_tdata[37:30];
    assign w_entry.flags = s_axis_tdata[53:38];

    // registers are simple flops: always ready
    assign o_cfg_ready = 1'b1;

    idft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    idft_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (s_axis_tdata[5:0]),
        .i_entry       (w_entry),
        .i_query_type  (s_axis_tdata[61:54]),
        .i_result_mask (s_axis_tdata[93:62]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_masked_sum  (m_axis_tdata)
    );

    // reads never run past the scan length
    `ASSERT_SAME(a_rd_in_range, i_clk, i_rst_n, w_cmd.rd_en, w_status.pos_lt_count)
    // a result never overwrites one still waiting
    `ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_cmd.finish, !m_axis_tvalid || m_axis_tready)
    // no transfer is taken while a table read is in flight
    `ASSERT_SAME(a_idle_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !w_status.rd_busy)
    // a finished query shows its result in the next cycle
    `ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.finish, m_axis_tvalid)

endmodule
